[rtl/mtg_pkg.sv]
// ----------------------------------------------------------------------------
// mtg_pkg
// Constants, types and word functions shared by the MT19937 generator.
// ----------------------------------------------------------------------------
package mtg_pkg;

  localparam int unsigned STATE_WORDS = 624;
  localparam int unsigned SHIFT_DIST  = 397;
  localparam int unsigned IDX_W       = $clog2(STATE_WORDS);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);

  localparam logic [31:0] INIT_MULT = 32'd1812433253;
  localparam logic [31:0] TWIST_XOR = 32'h9908_b0df;
  localparam logic [31:0] TEMPER_B  = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C  = 32'hefc6_0000;
  localparam logic [31:0] SEED_RST  = 32'd5489;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEED,
    ST_DRAW
  } mtg_state_e;

  typedef struct packed {
    logic push;
    logic last;
  } mtg_seed_t;

  function automatic logic [31:0] twist(input logic [31:0] head,
                                        input logic [31:0] next,
                                        input logic [31:0] far);
    logic [31:0] mixed;
    mixed = {head[31], next[30:0]};
    return far ^ (mixed >> 1) ^ (mixed[0] ? TWIST_XOR : 32'h0);
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] word);
    logic [31:0] y;
    y = word;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

[rtl/mtg_cell.sv]
// ----------------------------------------------------------------------------
// mtg_cell
// One state word of the generator chain; takes its neighbor's word on shift.
// ----------------------------------------------------------------------------
module mtg_cell (
  input  logic        clk_i,
  input  logic        shift_i,
  input  logic [31:0] word_i,
  output logic [31:0] word_o
);

  logic [31:0] word_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      word_q <= word_i;
    end
  end

  assign word_o = word_q;

endmodule

[rtl/mtg_seeder.sv]
// ----------------------------------------------------------------------------
// mtg_seeder
// Produces the 624 initial state words from the seed, one word per cycle.
// ----------------------------------------------------------------------------
module mtg_seeder
  import mtg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] seed_i,
  output logic [31:0] word_o,
  output mtg_seed_t   ctrl_o
);

  logic             busy_q, busy_d;
  logic [IDX_W-1:0] count_q, count_d;
  logic [31:0]      prev_q;
  logic [31:0]      mix;
  logic [31:0]      prod;

  assign mix  = prev_q ^ (prev_q >> 30);
  assign prod = mix * INIT_MULT;

  always_comb begin
    if (count_q == '0) begin
      word_o = seed_i;
    end else begin
      word_o = prod + {{(32 - IDX_W){1'b0}}, count_q};
    end
  end

  assign ctrl_o.push = busy_q;
  assign ctrl_o.last = busy_q && (count_q == LAST_IDX);

  always_comb begin
    busy_d  = busy_q;
    count_d = count_q;
    if (start_i) begin
      busy_d  = 1'b1;
      count_d = '0;
    end else if (busy_q) begin
      count_d = count_q + IDX_W'(1);
      if (count_q == LAST_IDX) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      count_q <= '0;
    end else begin
      busy_q  <= busy_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      prev_q <= word_o;
    end
  end

endmodule

[rtl/mt19937_generator.sv]
// ----------------------------------------------------------------------------
// mt19937_generator
// MT19937 draw engine: a 624-cell shift chain twists one word per draw.
// ----------------------------------------------------------------------------
// Plain draw: the result is registered and valid in the cycle after the input beat.
// Seeding draw (restart, or first draw after reset): the seeder pushes 624
//   words into the chain, one per cycle, then one twist yields the result.
// Throughput: one plain draw per cycle while out_ready_i takes the output.
// Reset: control cleared, generator unseeded, seed register back to 5489.
module mt19937_generator
  import mtg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] number_o
);

  mtg_state_e  state_q, state_d;
  logic [31:0] seed_q;
  logic        seeded_q;
  logic        out_valid_q, out_valid_d;
  logic [31:0] number_q;

  logic        in_ready;
  logic        accept;
  logic        need_seed;
  logic        seed_start;
  logic        draw_now;
  logic        shift;
  logic [31:0] tail_word;
  logic [31:0] twist_word;
  logic [31:0] seed_word;
  mtg_seed_t   seed_ctrl;

  logic [31:0] chain [STATE_WORDS];

  mtg_seeder u_seeder (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (seed_start),
    .seed_i  (seed_q),
    .word_o  (seed_word),
    .ctrl_o  (seed_ctrl)
  );

  for (genvar g = 0; g < STATE_WORDS; g++) begin : g_cell
    if (g == STATE_WORDS - 1) begin : g_tail
      mtg_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift),
        .word_i  (tail_word),
        .word_o  (chain[g])
      );
    end else begin : g_body
      mtg_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift),
        .word_i  (chain[g+1]),
        .word_o  (chain[g])
      );
    end
  end

  assign twist_word = twist(chain[0], chain[1], chain[SHIFT_DIST]);
  assign need_seed  = restart_i || !seeded_q;

  always_comb begin
    in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  end

  assign accept = in_valid_i && in_ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && need_seed) begin
          state_d = ST_SEED;
        end
      end
      ST_SEED: begin
        if (seed_ctrl.last) begin
          state_d = ST_DRAW;
        end
      end
      ST_DRAW: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    seed_start = accept && need_seed;
    draw_now   = (accept && !need_seed) || (state_q == ST_DRAW);
    shift      = draw_now || seed_ctrl.push;
    tail_word  = seed_ctrl.push ? seed_word : twist_word;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (draw_now) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seed_q      <= SEED_RST;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
      if (state_q == ST_DRAW) begin
        seeded_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (draw_now) begin
      number_q <= temper(twist_word);
    end
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign number_o    = number_q;

endmodule
